// File: design/dtn_pkg.sv
// Shared types, constants and helper functions for the date/time normalizer.
// Used by dtn_front, dtn_queue, dtn_back and date_time_normalizer_top.
package dtn_pkg;

   localparam int unsigned WORK_W  = 17;   // carried fields reach 68311 at most
   localparam int unsigned QUOT_W  = 13;   // largest quotient is 5461
   localparam int unsigned REM_W   = 10;   // largest remainder is 999
   localparam int unsigned PROD_W  = 40;
   localparam int unsigned RECIP_W = 19;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0]  MONTHS   = 4'd12;
   localparam logic [15:0] YEAR_MAX = 16'hFFFF;
   localparam logic [8:0]  Y400_MAX = 9'd399;
   localparam logic [6:0]  Y100_MAX = 7'd99;

   // Reciprocal divisions: q = (x * RECIP) >> SHIFT is exact over each dividend range.
   localparam logic [REM_W-1:0]   DIV_MILLI   = 10'd1000;
   localparam logic [REM_W-1:0]   DIV_SIXTY   = 10'd60;
   localparam logic [REM_W-1:0]   DIV_HOUR    = 10'd24;
   localparam logic [REM_W-1:0]   DIV_MONTH   = 10'd12;
   localparam logic [REM_W-1:0]   DIV_Y400    = 10'd400;
   localparam logic [REM_W-1:0]   DIV_Y100    = 10'd100;
   localparam logic [RECIP_W-1:0] RECIP_MILLI = 19'd67109;
   localparam logic [RECIP_W-1:0] RECIP_SIXTY = 19'd279621;
   localparam logic [RECIP_W-1:0] RECIP_HOUR  = 19'd174763;
   localparam logic [RECIP_W-1:0] RECIP_MONTH = 19'd87382;
   localparam logic [RECIP_W-1:0] RECIP_Y400  = 19'd167773;
   localparam logic [RECIP_W-1:0] RECIP_Y100  = 19'd656;
   localparam int unsigned SHIFT_MILLI = 26;
   localparam int unsigned SHIFT_SIXTY = 24;
   localparam int unsigned SHIFT_HOUR  = 22;
   localparam int unsigned SHIFT_MONTH = 20;
   localparam int unsigned SHIFT_Y400  = 26;
   localparam int unsigned SHIFT_Y100  = 16;

   typedef enum logic [2:0] {
      STEP_MILLI,
      STEP_SECOND,
      STEP_MINUTE,
      STEP_HOUR,
      STEP_MONTH,
      STEP_Y400,
      STEP_Y100
   } dtn_step_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_QUOT,
      F_REM,
      F_PUSH
   } dtn_front_state_type;

   typedef enum logic {
      B_IDLE,
      B_RUN
   } dtn_back_state_type;

   typedef struct packed {
      logic              bad;
      logic [15:0]       year;
      logic [3:0]        month;
      logic [WORK_W-1:0] day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic [9:0]        milli;
      logic [8:0]        mod400;
      logic [6:0]        mod100;
   } dtn_item_type;

   function automatic logic [REM_W-1:0] dtn_divisor(dtn_step_type step);
      logic [REM_W-1:0] d;
      case (step)
         STEP_MILLI:  d = DIV_MILLI;
         STEP_SECOND: d = DIV_SIXTY;
         STEP_MINUTE: d = DIV_SIXTY;
         STEP_HOUR:   d = DIV_HOUR;
         STEP_MONTH:  d = DIV_MONTH;
         STEP_Y400:   d = DIV_Y400;
         STEP_Y100:   d = DIV_Y100;
         default:     d = DIV_MILLI;
      endcase
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] dtn_recip(dtn_step_type step);
      logic [RECIP_W-1:0] r;
      case (step)
         STEP_MILLI:  r = RECIP_MILLI;
         STEP_SECOND: r = RECIP_SIXTY;
         STEP_MINUTE: r = RECIP_SIXTY;
         STEP_HOUR:   r = RECIP_HOUR;
         STEP_MONTH:  r = RECIP_MONTH;
         STEP_Y400:   r = RECIP_Y400;
         STEP_Y100:   r = RECIP_Y100;
         default:     r = RECIP_MILLI;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] dtn_month_len(logic [3:0] month, logic leap);
      logic [4:0] len;
      case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: design/dtn_front.sv
// Front end: accepts a timestamp, runs the time-field carries, month wrap and
// year residues through one shared reciprocal divider. Depends on dtn_pkg.
module dtn_front import dtn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [15:0]       year_in,
   input  logic [15:0]       month_in,
   input  logic [15:0]       day_in,
   input  logic [15:0]       hour_in,
   input  logic [15:0]       minute_in,
   input  logic [15:0]       second_in,
   input  logic [15:0]       milli_in,
   input  logic              full,
   output logic              busy,
   output logic              push,
   output dtn_item_type      push_item
);

   dtn_front_state_type state_ff, state_in;
   dtn_step_type        step_ff, step_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [15:0]         year_ff, year_in_n;
   logic [15:0]         month_ff, month_in_n;
   logic [WORK_W-1:0]   day_ff, day_in_n;
   logic [WORK_W-1:0]   hour_ff, hour_in_n;
   logic [WORK_W-1:0]   minute_ff, minute_in_n;
   logic [WORK_W-1:0]   second_ff, second_in_n;
   logic [WORK_W-1:0]   milli_ff, milli_in_n;
   logic [8:0]          mod400_ff, mod400_in;
   logic [6:0]          mod100_ff, mod100_in;
   logic                bad_ff, bad_in;

   logic [WORK_W-1:0]   dividend;
   logic [PROD_W-1:0]   product;
   logic [QUOT_W-1:0]   quot_sel;
   logic [WORK_W-1:0]   rem_full;
   logic [REM_W-1:0]    rem;

   always_comb begin
      case (step_ff)
         STEP_MILLI:  dividend = milli_ff;
         STEP_SECOND: dividend = second_ff;
         STEP_MINUTE: dividend = minute_ff;
         STEP_HOUR:   dividend = hour_ff;
         STEP_MONTH:  dividend = WORK_W'(month_ff) - WORK_W'(1);
         STEP_Y400:   dividend = WORK_W'(year_ff);
         STEP_Y100:   dividend = WORK_W'(mod400_ff);
         default:     dividend = '0;
      endcase
   end

   assign product = PROD_W'(dividend) * PROD_W'(dtn_recip(step_ff));

   always_comb begin
      case (step_ff)
         STEP_MILLI:  quot_sel = product[SHIFT_MILLI +: QUOT_W];
         STEP_SECOND: quot_sel = product[SHIFT_SIXTY +: QUOT_W];
         STEP_MINUTE: quot_sel = product[SHIFT_SIXTY +: QUOT_W];
         STEP_HOUR:   quot_sel = product[SHIFT_HOUR +: QUOT_W];
         STEP_MONTH:  quot_sel = product[SHIFT_MONTH +: QUOT_W];
         STEP_Y400:   quot_sel = product[SHIFT_Y400 +: QUOT_W];
         STEP_Y100:   quot_sel = product[SHIFT_Y100 +: QUOT_W];
         default:     quot_sel = '0;
      endcase
   end

   // Quotient is registered in F_QUOT; the remainder uses it in F_REM.
   assign rem_full = dividend - (WORK_W'(quot_ff) * WORK_W'(dtn_divisor(step_ff)));
   assign rem      = rem_full[REM_W-1:0];

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      quot_in     = quot_ff;
      year_in_n   = year_ff;
      month_in_n  = month_ff;
      day_in_n    = day_ff;
      hour_in_n   = hour_ff;
      minute_in_n = minute_ff;
      second_in_n = second_ff;
      milli_in_n  = milli_ff;
      mod400_in   = mod400_ff;
      mod100_in   = mod100_ff;
      bad_in      = bad_ff;
      push        = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               year_in_n   = year_in;
               month_in_n  = month_in;
               day_in_n    = WORK_W'(day_in);
               hour_in_n   = WORK_W'(hour_in);
               minute_in_n = WORK_W'(minute_in);
               second_in_n = WORK_W'(second_in);
               milli_in_n  = WORK_W'(milli_in);
               bad_in      = (month_in == 16'd0);
               step_in     = STEP_MILLI;
               // month zero skips all arithmetic
               state_in    = (month_in == 16'd0) ? F_PUSH : F_QUOT;
            end
         end
         F_QUOT: begin
            quot_in  = quot_sel;
            state_in = F_REM;
         end
         F_REM: begin
            state_in = F_QUOT;
            step_in  = dtn_step_type'(3'(step_ff + 3'd1));
            case (step_ff)
               STEP_MILLI: begin
                  milli_in_n  = WORK_W'(rem);
                  second_in_n = second_ff + WORK_W'(quot_ff);
               end
               STEP_SECOND: begin
                  second_in_n = WORK_W'(rem);
                  minute_in_n = minute_ff + WORK_W'(quot_ff);
               end
               STEP_MINUTE: begin
                  minute_in_n = WORK_W'(rem);
                  hour_in_n   = hour_ff + WORK_W'(quot_ff);
               end
               STEP_HOUR: begin
                  hour_in_n = WORK_W'(rem);
                  day_in_n  = day_ff + WORK_W'(quot_ff);
               end
               STEP_MONTH: begin
                  month_in_n = 16'(rem) + 16'd1;
                  year_in_n  = year_ff + 16'(quot_ff);
               end
               STEP_Y400: begin
                  mod400_in = rem[8:0];
               end
               STEP_Y100: begin
                  mod100_in = rem[6:0];
                  step_in   = step_ff;
                  state_in  = F_PUSH;
               end
               default: begin
                  state_in = F_IDLE;
               end
            endcase
         end
         F_PUSH: begin
            // hold until the queue has room
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      quot_ff   <= quot_in;
      year_ff   <= year_in_n;
      month_ff  <= month_in_n;
      day_ff    <= day_in_n;
      hour_ff   <= hour_in_n;
      minute_ff <= minute_in_n;
      second_ff <= second_in_n;
      milli_ff  <= milli_in_n;
      mod400_ff <= mod400_in;
      mod100_ff <= mod100_in;
      bad_ff    <= bad_in;
   end

   assign busy = (state_ff != F_IDLE);

   always_comb begin
      push_item.bad    = bad_ff;
      push_item.year   = year_ff;
      push_item.month  = month_ff[3:0];
      push_item.day    = day_ff;
      push_item.hour   = hour_ff[4:0];
      push_item.minute = minute_ff[5:0];
      push_item.second = second_ff[5:0];
      push_item.milli  = milli_ff[9:0];
      push_item.mod400 = mod400_ff;
      push_item.mod100 = mod100_ff;
   end

endmodule

// File: design/dtn_queue.sv
// Short queue of classified transactions between front end and day-carry back end.
// Depends on dtn_pkg for the item type and depth.
module dtn_queue import dtn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dtn_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output dtn_item_type pop_item
);

   dtn_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");

endmodule

// File: design/dtn_back.sv
// Back end: carries excess days one month per cycle with the Gregorian leap rule,
// then registers the result for a one-cycle strobe. Depends on dtn_pkg.
module dtn_back import dtn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         empty,
   input  dtn_item_type pop_item,
   output logic         pop,
   output logic         rsp_valid,
   output logic [15:0]  rsp_year_out,
   output logic [3:0]   rsp_month_out,
   output logic [4:0]   rsp_day_out,
   output logic [4:0]   rsp_hour_out,
   output logic [5:0]   rsp_minute_out,
   output logic [5:0]   rsp_second_out,
   output logic [9:0]   rsp_milli_out,
   output logic         rsp_bad_month
);

   dtn_back_state_type state_ff, state_in;
   dtn_item_type       item_ff, item_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        year_ff, year_in;
   logic [3:0]         month_ff, month_in;
   logic [4:0]         day_ff, day_in;
   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         minute_ff, minute_in;
   logic [5:0]         second_ff, second_in;
   logic [9:0]         milli_ff, milli_in;
   logic               bad_ff, bad_in;

   logic               leap;
   logic [4:0]         dim;
   logic               fits;

   // year mod 4 is the low two bits since 65536 is a multiple of 4
   assign leap = ((item_ff.year[1:0] == 2'd0) && (item_ff.mod100 != 7'd0))
               || (item_ff.mod400 == 9'd0);
   assign dim  = dtn_month_len(item_ff.month, leap);
   assign fits = (item_ff.day <= WORK_W'(dim));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_valid_in = 1'b0;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      milli_in     = milli_ff;
      bad_in       = bad_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               item_in  = pop_item;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (item_ff.bad || fits) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
               if (item_ff.bad) begin
                  year_in   = '0;
                  month_in  = '0;
                  day_in    = '0;
                  hour_in   = '0;
                  minute_in = '0;
                  second_in = '0;
                  milli_in  = '0;
                  bad_in    = 1'b1;
               end else begin
                  year_in   = item_ff.year;
                  month_in  = item_ff.month;
                  day_in    = item_ff.day[4:0];
                  hour_in   = item_ff.hour;
                  minute_in = item_ff.minute;
                  second_in = item_ff.second;
                  milli_in  = item_ff.milli;
                  bad_in    = 1'b0;
               end
            end else begin
               // drop this month's days and advance one month
               item_in.day = item_ff.day - WORK_W'(dim);
               if (item_ff.month == MONTHS) begin
                  item_in.month = 4'd1;
                  if (item_ff.year == YEAR_MAX) begin
                     item_in.year   = '0;
                     item_in.mod400 = '0;
                     item_in.mod100 = '0;
                  end else begin
                     item_in.year   = item_ff.year + 16'd1;
                     item_in.mod400 = (item_ff.mod400 == Y400_MAX) ? '0 : item_ff.mod400 + 9'd1;
                     item_in.mod100 = (item_ff.mod100 == Y100_MAX) ? '0 : item_ff.mod100 + 7'd1;
                  end
               end else begin
                  item_in.month = item_ff.month + 4'd1;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      milli_ff  <= milli_in;
      bad_ff    <= bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_year_out   = year_ff;
   assign rsp_month_out  = month_ff;
   assign rsp_day_out    = day_ff;
   assign rsp_hour_out   = hour_ff;
   assign rsp_minute_out = minute_ff;
   assign rsp_second_out = second_ff;
   assign rsp_milli_out  = milli_ff;
   assign rsp_bad_month  = bad_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !bad_ff) |-> ((month_ff >= 4'd1) && (month_ff <= MONTHS)))
      else $error("normalized month out of range");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");
   a_run_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN && !item_ff.bad) |-> ((item_ff.month >= 4'd1) && (item_ff.month <= MONTHS)))
      else $error("day carry working on an invalid month");

endmodule

// File: design/date_time_normalizer_top.sv
// Date/time normalizer: time-field carries and Gregorian day carry.
// Top level; instantiates dtn_front, dtn_queue and dtn_back, which import dtn_pkg.
//
// Usage: drive the req_ fields and raise start; the transaction is taken at a
// rising edge with start high and busy low. busy stays high while the front
// end works on it and until it lands in the two-entry queue; the front end
// then takes the next transaction while the back end still works.
// The result appears on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall and must take it then.
// Latency grows with every month that the excess days carry through, set by the
// back end's one-month-per-cycle loop; a zero month skips the front-end
// arithmetic. Sustained throughput is one transaction per back-end run when
// days overflow, else one per front-end pass.
// A month of zero raises rsp_bad_month with all other result fields zero.
// Reset (synchronous) empties the queue and returns both ends to idle; a
// transaction in flight is dropped.
module date_time_normalizer_top import dtn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_year_in,
   input  logic [15:0] req_month_in,
   input  logic [15:0] req_day_in,
   input  logic [15:0] req_hour_in,
   input  logic [15:0] req_minute_in,
   input  logic [15:0] req_second_in,
   input  logic [15:0] req_milli_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [9:0]  rsp_milli_out,
   output logic        rsp_bad_month
);

   logic         push;
   logic         pop;
   logic         full;
   logic         empty;
   dtn_item_type push_item;
   dtn_item_type pop_item;

   dtn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .year_in   (req_year_in),
      .month_in  (req_month_in),
      .day_in    (req_day_in),
      .hour_in   (req_hour_in),
      .minute_in (req_minute_in),
      .second_in (req_second_in),
      .milli_in  (req_milli_in),
      .full      (full),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   dtn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .pop_item  (pop_item)
   );

   dtn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .pop_item       (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_milli_out  (rsp_milli_out),
      .rsp_bad_month  (rsp_bad_month)
   );

endmodule

// File: bench/tb_date_time_normalizer_top.sv
`timescale 1ns / 1ps
// Self-checking bench for date_time_normalizer_top: directed timestamps, then random ones.
// Needs only the RTL in design/; results are predicted here from the Gregorian rules.
module tb_date_time_normalizer_top;

   typedef struct packed {
      logic [15:0] year;
      logic [15:0] month;
      logic [15:0] day;
      logic [15:0] hour;
      logic [15:0] minute;
      logic [15:0] second;
      logic [15:0] milli;
   } stamp_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  milli;
      logic        bad;
   } norm_type;

   typedef struct packed {
      stamp_type stamp;
      logic      typed;
      norm_type  want;
   } vector_type;

   localparam norm_type NO_NORM = '0;
   localparam int NUM_DIRECTED = 20;
   localparam int NUM_RANDOM   = 250;
   localparam int TAIL_CYCLES  = 40;

   // Rows with typed set carry their result; the others go through the predictor.
   localparam vector_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{'{16'd2024, 16'd0, 16'd15, 16'd12, 16'd30, 16'd30, 16'd500}, 1'b1,
        '{16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1}},
      '{'{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1}},
      '{'{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd2024, 16'd2, 16'd29, 16'd23, 16'd59, 16'd59, 16'd999}, 1'b1,
        '{16'd2024, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 10'd999, 1'b0}},
      '{'{16'd2023, 16'd2, 16'd29, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd2023, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd2000, 16'd2, 16'd29, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd1900, 16'd2, 16'd29, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'hFFFF, 16'd12, 16'd32, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'hFFFF, 16'd13, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd2023, 16'd12, 16'd31, 16'd23, 16'd59, 16'd59, 16'd1000}, 1'b1,
        '{16'd2024, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd2024, 16'd24, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
        '{16'd2025, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0}},
      '{'{16'd2024, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd999}, 1'b1,
        '{16'd2024, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 10'd999, 1'b0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, NO_NORM},
      '{'{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, NO_NORM},
      '{'{16'd2024, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, NO_NORM},
      '{'{16'd0, 16'd12, 16'd0, 16'd24, 16'd0, 16'd0, 16'd0}, 1'b0, NO_NORM},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
        1'b0, NO_NORM},
      '{'{16'd2100, 16'd2, 16'd29, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, NO_NORM},
      '{'{16'd1996, 16'd2, 16'd28, 16'd24, 16'd0, 16'd0, 16'd0}, 1'b0, NO_NORM},
      '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
        1'b0, NO_NORM}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_year_in   = '0;
   logic [15:0] req_month_in  = '0;
   logic [15:0] req_day_in    = '0;
   logic [15:0] req_hour_in   = '0;
   logic [15:0] req_minute_in = '0;
   logic [15:0] req_second_in = '0;
   logic [15:0] req_milli_in  = '0;
   logic        rsp_valid;
   logic [15:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic [9:0]  rsp_milli_out;
   logic        rsp_bad_month;

   norm_type pending_norms [$];
   int    mismatches      = 0;
   int    results_checked = 0;
   int    items_sent      = 0;
   int    zero_months     = 0;
   int    long_carries    = 0;

   always #5 clock = ~clock;

   date_time_normalizer_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_year_in    (req_year_in),
      .req_month_in   (req_month_in),
      .req_day_in     (req_day_in),
      .req_hour_in    (req_hour_in),
      .req_minute_in  (req_minute_in),
      .req_second_in  (req_second_in),
      .req_milli_in   (req_milli_in),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_milli_out  (rsp_milli_out),
      .rsp_bad_month  (rsp_bad_month)
   );

   // Carry the time fields upward, fold the month into the year, then walk excess days
   // one month at a time with the Gregorian month lengths.
   function automatic norm_type normalize_stamp(stamp_type s);
      norm_type    res;
      int unsigned yr, mon, dy, hr, mn, sc, ms, dim;
      logic        leap;
      res = '0;
      if (s.month == 16'd0) begin
         res.bad = 1'b1;
         return res;
      end
      ms  = 32'(s.milli);
      sc  = 32'(s.second) + ms / 1000;
      ms  = ms % 1000;
      mn  = 32'(s.minute) + sc / 60;
      sc  = sc % 60;
      hr  = 32'(s.hour) + mn / 60;
      mn  = mn % 60;
      dy  = 32'(s.day) + hr / 24;
      hr  = hr % 24;
      yr  = (32'(s.year) + (32'(s.month) - 1) / 12) & 32'hFFFF;
      mon = (32'(s.month) - 1) % 12 + 1;
      forever begin
         leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
         case (mon)
            2:           dim = leap ? 29 : 28;
            4, 6, 9, 11: dim = 30;
            default:     dim = 31;
         endcase
         if (dy <= dim) break;
         dy  = dy - dim;
         mon = mon + 1;
         if (mon > 12) begin
            mon = 1;
            yr  = (yr + 1) & 32'hFFFF;
         end
      end
      res.year   = yr[15:0];
      res.month  = mon[3:0];
      res.day    = dy[4:0];
      res.hour   = hr[4:0];
      res.minute = mn[5:0];
      res.second = sc[5:0];
      res.milli  = ms[9:0];
      return res;
   endfunction

   // Hold start and the fields until the transaction is taken, then queue its result.
   task automatic send_stamp(input stamp_type s, input logic typed, input norm_type want);
      req_year_in   <= s.year;
      req_month_in  <= s.month;
      req_day_in    <= s.day;
      req_hour_in   <= s.hour;
      req_minute_in <= s.minute;
      req_second_in <= s.second;
      req_milli_in  <= s.milli;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      pending_norms.push_back(typed ? want : normalize_stamp(s));
      items_sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (pending_norms.size() != 0);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      norm_type want;
      if (!reset && rsp_valid) begin
         if (pending_norms.size() == 0) begin
            $display("%0t: result with nothing pending: expected none, actual year %0d",
                     $time, rsp_year_out);
            mismatches++;
         end else begin
            want = pending_norms.pop_front();
            compare_field("year",      32'(want.year),   32'(rsp_year_out));
            compare_field("month",     32'(want.month),  32'(rsp_month_out));
            compare_field("day",       32'(want.day),    32'(rsp_day_out));
            compare_field("hour",      32'(want.hour),   32'(rsp_hour_out));
            compare_field("minute",    32'(want.minute), 32'(rsp_minute_out));
            compare_field("second",    32'(want.second), 32'(rsp_second_out));
            compare_field("milli",     32'(want.milli),  32'(rsp_milli_out));
            compare_field("bad_month", 32'(want.bad),    32'(rsp_bad_month));
            results_checked++;
         end
      end
   end

   initial begin
      stamp_type   s;
      int unsigned pick, yr;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_stamp(DIRECTED_ROWS[i].stamp, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      drain_pending();

      for (int idx = 0; idx < NUM_RANDOM; idx++) begin
         s.year   = 16'($urandom_range(65535));
         s.month  = 16'($urandom_range(65535));
         s.day    = 16'($urandom_range(65535));
         s.hour   = 16'($urandom_range(65535));
         s.minute = 16'($urandom_range(65535));
         s.second = 16'($urandom_range(65535));
         s.milli  = 16'($urandom_range(65535));
         pick = $urandom_range(99);
         if (pick < 55) begin
            // plausible dates, nudged just past each field's natural limit now and then
            s.month  = 16'($urandom_range(13, 1));
            s.day    = 16'($urandom_range(35));
            s.hour   = 16'($urandom_range(26));
            s.minute = 16'($urandom_range(62));
            s.second = 16'($urandom_range(62));
            s.milli  = 16'($urandom_range(1005));
            if ($urandom_range(3) == 0) s.year = 16'(32'hFFFF - $urandom_range(1));
         end else if (pick < 70) begin
            // end of February around leap, century and 400-year years
            case ($urandom_range(3))
               0:       yr = $urandom_range(163) * 400;
               1:       yr = $urandom_range(655) * 100;
               2:       yr = $urandom_range(16383) * 4;
               default: yr = $urandom_range(65535);
            endcase
            s.year   = yr[15:0];
            s.month  = $urandom_range(1) ? 16'd2 : 16'd14;
            s.day    = 16'($urandom_range(32, 27));
            s.hour   = 16'($urandom_range(24));
            s.minute = 16'($urandom_range(60));
            s.second = 16'($urandom_range(60));
            s.milli  = 16'($urandom_range(1000));
         end else if (pick < 90) begin
            s.day = 16'($urandom_range(400));
         end else if (pick >= 95) begin
            s.month = '0;
         end
         if (s.month == 16'd0) zero_months++;
         if (s.day > 16'd400) long_carries++;
         send_stamp(s, 1'b0, NO_NORM);
         if (idx == 200) begin
            drain_pending();
         end else if (!(idx >= 80 && idx < 160) && $urandom_range(99) < 7) begin
            pause_sender($urandom_range(12, 1));
         end
      end

      drain_pending();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d timestamps (%0d directed), checked %0d results.",
               items_sent, NUM_DIRECTED, results_checked);
      $display("Random set held %0d zero months and %0d long day carries.",
               zero_months, long_carries);
      if (mismatches == 0 && pending_norms.size() == 0) begin
         $display("PASS date_time_normalizer_top");
      end else begin
         $display("FAIL date_time_normalizer_top");
      end
      $finish;
   end

   // Slowest legal run is a few ms; allow several times that.
   initial begin
      #50_000_000;
      $display("FAIL date_time_normalizer_top");
      $finish;
   end

endmodule
